// ===== sv/gmfv_pkg.sv =====
// ----------------------------------------------------------------------------
// gmfv_pkg
// Types, constants and register codes shared by the grid mesh face validator.
// ----------------------------------------------------------------------------
package gmfv_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_ROWS_DEF  = 1024;

  localparam int COORD_W    = 24;
  localparam int MAG_W      = 24;
  localparam int SQ_W       = 48;
  localparam int LIMIT_W    = 50;
  localparam int GW_W       = 11;
  localparam int CELL_W     = 10;
  localparam int FACE_W     = 21;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 50;

  localparam logic [LIMIT_W-1:0] LIMIT_RST = 50'd429497;
  localparam logic [GW_W-1:0]    GW_RST    = 11'd640;
  localparam logic [FACE_W-1:0]  FACE_CAP  = 21'h1FFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EDGE_LIMIT_SQ = 4'd0,
    REG_GRID_WIDTH    = 4'd1
  } cfg_reg_t;

  typedef struct packed {
    logic                      valid;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } vtx_t;

  typedef struct packed {
    logic                      start_of_frame;
    logic                      vertex_valid;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_row;
    logic [CELL_W-1:0] cell_col;
    logic              upper_face_ok;
    logic              lower_face_ok;
    logic [FACE_W-1:0] faces_so_far;
  } out_item_t;

  // per-item control that follows the vertex data down the pipe
  typedef struct packed {
    logic              emit;
    logic              sof;
    logic [CELL_W-1:0] cell_row;
    logic [CELL_W-1:0] cell_col;
  } tag_t;

endpackage

// ===== sv/gmfv_line_store.sv =====
// ----------------------------------------------------------------------------
// gmfv_line_store
// Previous-row vertex memory, one write port and one registered read port,
// with a one-entry deferred write for the row-end vertex.
// ----------------------------------------------------------------------------
module gmfv_line_store #(
  parameter int DEPTH = gmfv_pkg::MAX_WIDTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output gmfv_pkg::vtx_t  rd_data,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  gmfv_pkg::vtx_t  wr_data,
  input  logic            defer_en,
  input  logic [AW-1:0]   defer_addr,
  input  gmfv_pkg::vtx_t  defer_data
);

  gmfv_pkg::vtx_t mem [DEPTH];
  gmfv_pkg::vtx_t rd_data_r;

  logic           pend_valid_r;
  logic [AW-1:0]  pend_addr_r;
  gmfv_pkg::vtx_t pend_data_r;

  // the transfer after a row end is always column 0, which needs no write,
  // so the deferred entry goes in before or with it and never meets a normal write;
  // it is also never read in that cycle since column 0 reads entry 0
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else begin
      pend_valid_r <= defer_en;
    end
  end

  always_ff @(posedge clk) begin
    if (defer_en) begin
      pend_addr_r <= defer_addr;
      pend_data_r <= defer_data;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_valid_r) begin
      mem[pend_addr_r] <= pend_data_r;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/gmfv_edge_pipe.sv =====
// ----------------------------------------------------------------------------
// gmfv_edge_pipe
// Four-stage judge: item registers, edge differences, squares, then squared-length
// compare and triangle decision for the two faces of one grid cell.
// ----------------------------------------------------------------------------
module gmfv_edge_pipe (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_fire,
  input  gmfv_pkg::tag_t                   in_tag,
  input  gmfv_pkg::vtx_t                   in_cur,
  input  gmfv_pkg::vtx_t                   in_bl,
  input  gmfv_pkg::vtx_t                   tr_q,
  input  logic [gmfv_pkg::LIMIT_W-1:0]     limit,
  output logic                             s4_valid,
  output gmfv_pkg::tag_t                   s4_tag,
  output logic                             s4_upper_ok,
  output logic                             s4_lower_ok
);

  localparam int N_EDGE = 5;
  localparam int N_AXIS = 3;
  localparam int N_PT   = 4;

  // vertex slots
  localparam int P_TL  = 0;
  localparam int P_TR  = 1;
  localparam int P_BL  = 2;
  localparam int P_CUR = 3;

  // edges
  localparam int E_TLTR  = 0;
  localparam int E_TLBL  = 1;
  localparam int E_TRBL  = 2;
  localparam int E_TRCUR = 3;
  localparam int E_CURBL = 4;

  localparam int EDGE_A [N_EDGE] = '{P_TL, P_TL, P_TR, P_TR, P_CUR};
  localparam int EDGE_B [N_EDGE] = '{P_TR, P_BL, P_BL, P_CUR, P_BL};

  function automatic logic signed [gmfv_pkg::COORD_W-1:0] coord(
    input gmfv_pkg::vtx_t v, input int axis);
    logic signed [gmfv_pkg::COORD_W-1:0] c;
    unique case (axis)
      0:       c = v.x;
      1:       c = v.y;
      default: c = v.z;
    endcase
    return c;
  endfunction

  function automatic logic [gmfv_pkg::MAG_W-1:0] abs_diff(
    input logic signed [gmfv_pkg::COORD_W-1:0] a,
    input logic signed [gmfv_pkg::COORD_W-1:0] b);
    logic [gmfv_pkg::COORD_W:0] d;
    logic [gmfv_pkg::COORD_W:0] neg;
    d   = {a[gmfv_pkg::COORD_W-1], a} - {b[gmfv_pkg::COORD_W-1], b};
    neg = -d;
    return d[gmfv_pkg::COORD_W] ? neg[gmfv_pkg::MAG_W-1:0] : d[gmfv_pkg::MAG_W-1:0];
  endfunction

  // stage 1: item registers, memory data arrives alongside
  logic           v1_r;
  gmfv_pkg::tag_t tag1_r;
  gmfv_pkg::vtx_t cur1_r;
  gmfv_pkg::vtx_t bl1_r;
  gmfv_pkg::vtx_t tl_r;

  // stage 2: edge magnitudes
  logic                       v2_r;
  gmfv_pkg::tag_t             tag2_r;
  logic [N_PT-1:0]            pv2_r;
  logic [gmfv_pkg::MAG_W-1:0] mag2_r [N_EDGE][N_AXIS];
  logic [gmfv_pkg::MAG_W-1:0] mag2_nxt [N_EDGE][N_AXIS];

  // stage 3: squares
  logic                       v3_r;
  gmfv_pkg::tag_t             tag3_r;
  logic [N_PT-1:0]            pv3_r;
  logic [gmfv_pkg::SQ_W-1:0]  sq3_r [N_EDGE][N_AXIS];

  // stage 4: face decisions
  logic                       v4_r;
  gmfv_pkg::tag_t             tag4_r;
  logic                       up4_r;
  logic                       lo4_r;

  gmfv_pkg::vtx_t             pts [N_PT];
  logic [N_EDGE-1:0]          edge_ok;
  logic                       up_nxt;
  logic                       lo_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_fire;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // top-left of column c is the top-right that column c-1 read
  always_ff @(posedge clk) begin
    if (en && v1_r) begin
      tl_r <= tr_q;
    end
  end

  always_comb begin
    pts[P_TL]  = tl_r;
    pts[P_TR]  = tr_q;
    pts[P_BL]  = bl1_r;
    pts[P_CUR] = cur1_r;
    for (int e = 0; e < N_EDGE; e++) begin
      for (int a = 0; a < N_AXIS; a++) begin
        mag2_nxt[e][a] = abs_diff(coord(pts[EDGE_A[e]], a), coord(pts[EDGE_B[e]], a));
      end
    end
  end

  always_comb begin
    logic [gmfv_pkg::LIMIT_W-1:0] sum;
    for (int e = 0; e < N_EDGE; e++) begin
      sum = gmfv_pkg::LIMIT_W'(sq3_r[e][0]) + gmfv_pkg::LIMIT_W'(sq3_r[e][1])
          + gmfv_pkg::LIMIT_W'(sq3_r[e][2]);
      edge_ok[e] = (sum <= limit);
    end
    up_nxt = pv3_r[P_TL] & pv3_r[P_TR] & pv3_r[P_BL]
           & edge_ok[E_TLTR] & edge_ok[E_TLBL] & edge_ok[E_TRBL];
    lo_nxt = pv3_r[P_TR] & pv3_r[P_CUR] & pv3_r[P_BL]
           & edge_ok[E_TRCUR] & edge_ok[E_TRBL] & edge_ok[E_CURBL];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag1_r <= in_tag;
      cur1_r <= in_cur;
      bl1_r  <= in_bl;

      tag2_r <= tag1_r;
      pv2_r  <= {cur1_r.valid, bl1_r.valid, tr_q.valid, tl_r.valid};
      mag2_r <= mag2_nxt;

      tag3_r <= tag2_r;
      pv3_r  <= pv2_r;
      for (int e = 0; e < N_EDGE; e++) begin
        for (int a = 0; a < N_AXIS; a++) begin
          sq3_r[e][a] <= mag2_r[e][a] * mag2_r[e][a];
        end
      end

      tag4_r <= tag3_r;
      up4_r  <= up_nxt;
      lo4_r  <= lo_nxt;
    end
  end

  assign s4_valid    = v4_r;
  assign s4_tag      = tag4_r;
  assign s4_upper_ok = up4_r;
  assign s4_lower_ok = lo4_r;

endmodule

// ===== sv/grid_mesh_face_validator.sv =====
// ----------------------------------------------------------------------------
// grid_mesh_face_validator
// Judges the two triangles of each organized point cloud grid cell from a
// raster vertex stream, with a running count of kept faces.
//
//   channel  direction  handshake        payload
//   in_      input      valid / stall    gmfv_pkg::in_item_t
//   out_     output     valid / stall    gmfv_pkg::out_item_t
//   cfg_     input      valid / ready    register index, write data
//
// One vertex is taken every cycle unless a held result stalls the pipe; the
// line store's single write port sets that rate: the row-end vertex is
// written before or with the column-0 transfer that follows.
// Reset clears counters, configuration registers and pipe valid bits; the line store is not
// cleared and holds nothing meaningful until a row has been written.
// A result held under out_stall freezes the whole pipe and raises in_stall.
// ----------------------------------------------------------------------------
module grid_mesh_face_validator #(
  parameter int MAX_WIDTH = gmfv_pkg::MAX_WIDTH_DEF,
  parameter int MAX_ROWS  = gmfv_pkg::MAX_ROWS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  gmfv_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output gmfv_pkg::out_item_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [gmfv_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gmfv_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int AW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_ROWS);
  localparam int WW0  = $clog2(MAX_WIDTH + 1);
  localparam int WW   = (WW0 > gmfv_pkg::GW_W) ? WW0 : gmfv_pkg::GW_W;
  localparam int CX_W = AW + gmfv_pkg::CELL_W;
  localparam int RX_W = RW + gmfv_pkg::CELL_W;

  localparam logic [WW-1:0] W_MIN    = WW'(2);
  localparam logic [WW-1:0] W_MAX    = WW'(MAX_WIDTH);
  localparam logic [RW:0]   ROWS_LIM = (RW + 1)'(MAX_ROWS);
  localparam logic [RW-1:0] ROW_TOP  = RW'(MAX_ROWS - 1);

  function automatic logic [RW-1:0] next_row(input logic [RW-1:0] r);
    logic [RW:0] rp;
    rp = {1'b0, r} + 1'b1;
    return (rp >= ROWS_LIM) ? ROW_TOP : rp[RW-1:0];
  endfunction

  // configuration
  logic [gmfv_pkg::LIMIT_W-1:0] edge_limit_r;
  logic [gmfv_pkg::GW_W-1:0]    grid_width_r;

  // position and previous vertex
  logic [AW-1:0]    col_count_r;
  logic [AW-1:0]    col_count_nxt;
  logic [RW-1:0]    row_count_r;
  logic [RW-1:0]    row_count_nxt;
  gmfv_pkg::vtx_t   prev_r;

  // output side
  logic                        out_valid_r;
  gmfv_pkg::out_item_t         out_data_r;
  logic [gmfv_pkg::FACE_W-1:0] face_r;
  logic [gmfv_pkg::FACE_W-1:0] face_nxt;

  logic             en;
  logic             fire;
  logic [WW-1:0]    gw_ext;
  logic [WW-1:0]    w_eff;
  logic [AW-1:0]    col_cur;
  logic [RW-1:0]    row_cur;
  logic             last_col;
  logic [AW-1:0]    col_m1;
  logic [RW-1:0]    row_m1;
  logic [CX_W-1:0]  col_x;
  logic [RX_W-1:0]  row_x;
  gmfv_pkg::vtx_t   cur_vtx;
  gmfv_pkg::tag_t   tag0;
  gmfv_pkg::vtx_t   tr_q;

  logic             s4_valid;
  gmfv_pkg::tag_t   s4_tag;
  logic             s4_upper_ok;
  logic             s4_lower_ok;

  assign en        = !out_valid_r || !out_stall;
  assign fire      = in_valid && en;
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_limit_r <= gmfv_pkg::LIMIT_RST;
      grid_width_r <= gmfv_pkg::GW_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        gmfv_pkg::REG_EDGE_LIMIT_SQ: edge_limit_r <= cfg_data[gmfv_pkg::LIMIT_W-1:0];
        gmfv_pkg::REG_GRID_WIDTH:    grid_width_r <= cfg_data[gmfv_pkg::GW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    gw_ext = WW'(grid_width_r);
    if (gw_ext < W_MIN) begin
      w_eff = W_MIN;
    end else if (gw_ext > W_MAX) begin
      w_eff = W_MAX;
    end else begin
      w_eff = gw_ext;
    end
  end

  always_comb begin
    if (in_data.start_of_frame) begin
      col_cur = '0;
      row_cur = '0;
    end else if (WW'(col_count_r) >= w_eff) begin
      // width shrank under the current column: start a new row
      col_cur = '0;
      row_cur = next_row(row_count_r);
    end else begin
      col_cur = col_count_r;
      row_cur = row_count_r;
    end
    last_col = (WW'(col_cur) + 1'b1) >= w_eff;
    if (last_col) begin
      col_count_nxt = '0;
      row_count_nxt = next_row(row_cur);
    end else begin
      col_count_nxt = col_cur + 1'b1;
      row_count_nxt = row_cur;
    end
    col_m1 = col_cur - 1'b1;
    row_m1 = row_cur - 1'b1;
    col_x  = CX_W'(col_m1);
    row_x  = RX_W'(row_m1);
  end

  always_comb begin
    cur_vtx.valid = in_data.vertex_valid;
    cur_vtx.x     = in_data.pos_x;
    cur_vtx.y     = in_data.pos_y;
    cur_vtx.z     = in_data.pos_z;
    tag0.emit     = (col_cur != '0) && (row_cur != '0);
    tag0.sof      = in_data.start_of_frame;
    tag0.cell_row = row_x[gmfv_pkg::CELL_W-1:0];
    tag0.cell_col = col_x[gmfv_pkg::CELL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r <= '0;
      row_count_r <= '0;
      prev_r      <= '0;
    end else if (fire) begin
      col_count_r <= col_count_nxt;
      row_count_r <= row_count_nxt;
      prev_r      <= cur_vtx;
    end
  end

  gmfv_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_line_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_en      (fire),
    .rd_addr    (col_cur),
    .rd_data    (tr_q),
    .wr_en      (fire && (col_cur != '0)),
    .wr_addr    (col_m1),
    .wr_data    (prev_r),
    .defer_en   (fire && last_col),
    .defer_addr (col_cur),
    .defer_data (cur_vtx)
  );

  gmfv_edge_pipe u_edge_pipe (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_fire     (fire),
    .in_tag      (tag0),
    .in_cur      (cur_vtx),
    .in_bl       (prev_r),
    .tr_q        (tr_q),
    .limit       (edge_limit_r),
    .s4_valid    (s4_valid),
    .s4_tag      (s4_tag),
    .s4_upper_ok (s4_upper_ok),
    .s4_lower_ok (s4_lower_ok)
  );

  // only a completed cell adds faces; row 0 and column 0 verdicts are junk
  always_comb begin
    logic [gmfv_pkg::FACE_W:0] sum;
    sum = (s4_tag.sof ? '0 : {1'b0, face_r})
        + (gmfv_pkg::FACE_W + 1)'(s4_upper_ok & s4_tag.emit)
        + (gmfv_pkg::FACE_W + 1)'(s4_lower_ok & s4_tag.emit);
    if (sum > (gmfv_pkg::FACE_W + 1)'(gmfv_pkg::FACE_CAP)) begin
      face_nxt = gmfv_pkg::FACE_CAP;
    end else begin
      face_nxt = sum[gmfv_pkg::FACE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      face_r      <= '0;
    end else if (en) begin
      out_valid_r <= s4_valid && s4_tag.emit;
      if (s4_valid) begin
        face_r <= face_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r.cell_row      <= s4_tag.cell_row;
      out_data_r.cell_col      <= s4_tag.cell_col;
      out_data_r.upper_face_ok <= s4_upper_ok;
      out_data_r.lower_face_ok <= s4_lower_ok;
      out_data_r.faces_so_far  <= face_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sv/gmfv_checker.sv =====
// ----------------------------------------------------------------------------
// gmfv_checker
// Port-level checks for the grid mesh face validator, bound to the top level.
// ----------------------------------------------------------------------------
module gmfv_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  gmfv_pkg::in_item_t                in_data,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  gmfv_pkg::out_item_t               out_data
);

  // a blocked result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // a stalled vertex stays put on the input side too
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled vertex changed");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  // a blocked result freezes the pipe, so no vertex may get in
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while result blocked");

  // a kept face is counted, and the count saturates instead of wrapping
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.upper_face_ok || out_data.lower_face_ok)
      |-> out_data.faces_so_far != '0)
    else $error("kept face with zero face count");

endmodule

bind grid_mesh_face_validator gmfv_checker u_gmfv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
